// File: rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the modular exponentiation core
// no dependencies

package mexp_pkg;

    localparam int unsigned OPERAND_WIDTH_DEFAULT = 31;
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// top level of the modular exponentiation core: base^exponent mod modulus
// depends on mexp_pkg (state type, default width, modulus reset value)

// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result on o_power_residue is marked
// by o_result_strobe for exactly one cycle, and the receiver cannot hold it
// off; the next word can go in the cycle after the strobe. The work is done
// by the single shared modular multiplier, which consumes one multiplier bit
// per cycle, after the base is first reduced by restoring shift-subtract.
// A modulus of 0 or 1 shows 0 in the cycle right after the accepting edge.
// The modulus register accepts a write whenever the core is not busy and no
// word is offered on start; it resets to 1000000007.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic [OPERAND_WIDTH-1:0] i_base_value,
    input  logic [OPERAND_WIDTH-1:0] i_exponent_value,
    // result
    output logic                     o_result_strobe,
    output logic [OPERAND_WIDTH-1:0] o_power_residue,
    // modulus write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [OPERAND_WIDTH-1:0] i_cfg_data
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);

    t_state r_state, n_state;

    logic [W-1:0]  r_modulus;
    logic [W-1:0]  r_res;      // running result
    logic [W-1:0]  r_base;     // current base power
    logic [W-1:0]  r_exp;      // remaining exponent bits
    logic [W-1:0]  r_acc;      // product / remainder accumulator
    logic [W-1:0]  r_a;        // doubled addend of the multiplier
    logic [W-1:0]  r_mult;     // multiplier bits, or base bits being reduced
    logic [CW-1:0] r_count;
    logic          r_mul_res;  // current product goes to the running result

    logic          accept;
    logic          last_bit;
    logic [W:0]    red_t;      // shifted remainder during base reduction
    logic [W-1:0]  red_next;
    logic [W:0]    add_sum;    // acc + a
    logic [W-1:0]  acc_next;
    logic [W:0]    dbl;        // 2a
    logic [W-1:0]  a_next;

    assign accept   = start && !busy;
    assign last_bit = (r_count == CW'(1));

    // one restoring step of base mod modulus
    always_comb begin
        red_t    = {r_acc, r_mult[W-1]};
        red_next = (red_t >= {1'b0, r_modulus}) ? W'(red_t - {1'b0, r_modulus})
                                                 : red_t[W-1:0];
    end

    // one bit of the lsb-first modular product: conditional add and doubling
    // work side by side, never chained
    always_comb begin
        add_sum  = {1'b0, r_acc} + {1'b0, r_a};
        if (!r_mult[0]) begin
            acc_next = r_acc;
        end else if (add_sum >= {1'b0, r_modulus}) begin
            acc_next = W'(add_sum - {1'b0, r_modulus});
        end else begin
            acc_next = add_sum[W-1:0];
        end
        dbl    = {r_a, 1'b0};
        a_next = (dbl >= {1'b0, r_modulus}) ? W'(dbl - {1'b0, r_modulus}) : dbl[W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (r_modulus <= W'(1)) ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (last_bit) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (r_exp == '0) ? ST_FINISH : ST_MUL;
            end
            ST_MUL: begin
                if (last_bit && !r_mul_res) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy            = 1'b1;
        o_result_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_FINISH: begin
                o_result_strobe = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
        // no write in the same cycle as a word, so a word never sees two moduli
        o_cfg_ready = !busy && !start;
    end

    assign o_power_residue = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= MODULUS_RESET[W-1:0];
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_modulus <= i_cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_res   <= '0;
                    r_acc   <= '0;
                    r_mult  <= i_base_value;
                    r_exp   <= i_exponent_value;
                    r_count <= CW'(W);
                end
            end
            ST_REDUCE: begin
                r_acc   <= red_next;
                r_mult  <= {r_mult[W-2:0], 1'b0};
                r_count <= r_count - CW'(1);
                if (last_bit) begin
                    r_base <= red_next;
                    r_res  <= W'(1);
                end
            end
            ST_CHECK: begin
                // multiply into the result first when the exponent bit is set
                r_acc     <= '0;
                r_a       <= r_base;
                r_mult    <= r_exp[0] ? r_res : r_base;
                r_mul_res <= r_exp[0];
                r_count   <= CW'(W);
            end
            ST_MUL: begin
                r_acc   <= acc_next;
                r_a     <= a_next;
                r_mult  <= {1'b0, r_mult[W-1:1]};
                r_count <= r_count - CW'(1);
                if (last_bit) begin
                    if (r_mul_res) begin
                        // result updated, now square the base
                        r_res     <= acc_next;
                        r_acc     <= '0;
                        r_a       <= r_base;
                        r_mult    <= r_base;
                        r_mul_res <= 1'b0;
                        r_count   <= CW'(W);
                    end else begin
                        r_base <= acc_next;
                        r_exp  <= {1'b0, r_exp[W-1:1]};
                    end
                end
            end
            ST_FINISH: begin
                r_count <= r_count;
            end
            default: begin
                r_count <= r_count;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result only follows a busy cycle or an accepted word
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy || accept))
        else $error("result strobe without preceding work");

    // an accepted word keeps the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("core not busy after accepting a word");

    // the core is free again right after the result
    a_strobe_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !busy)
        else $error("core still busy after result");

    // residues stay below the modulus while working
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_REDUCE) |-> (r_acc < r_modulus))
        else $error("accumulator not reduced");

    // the result is a proper residue
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && r_modulus > W'(1)) |-> (o_power_residue < r_modulus))
        else $error("result not below modulus");
`endif

endmodule

// File: test/modular_exponentiation_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for modular_exponentiation_core (base^exponent mod modulus)
// depends on mexp_pkg and the core rtl; needs no files or arguments

module modular_exponentiation_core_tb;
    import mexp_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH_DEFAULT;
    localparam logic [W-1:0] OPERAND_MAX = {W{1'b1}};
    localparam logic [W-1:0] MODULUS_AT_RESET = MODULUS_RESET[W-1:0];
    // no handshake of any kind for this many cycles ends the run; the limit
    // lies well above the slowest word and the longest sender gap
    localparam int unsigned STALL_LIMIT = 20000;
    // quiet time after the last result: worst-case latency plus margin
    localparam int unsigned TAIL_CYCLES = 2100;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned WORDS_PER_PHASE = 34;

    // directed table rows: either a modulus write or a command word
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic         typed;    // want holds a hand-worked result
        logic [W-1:0] a;        // base, or modulus for a write row
        logic [W-1:0] b;        // exponent
        logic [W-1:0] want;
    } t_row;

    // dut signals; those the bench drives are at known values from time zero
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] i_base_value = '0;
    logic [W-1:0] i_exponent_value = '0;
    logic         o_result_strobe;
    logic [W-1:0] o_power_residue;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_data = '0;

    // shadow of the modulus register and the residues still to come
    logic [W-1:0] modulus_shadow = MODULUS_AT_RESET;
    logic [W-1:0] residue_q[$];
    logic [W-1:0] residue_want;
    t_row         directed_rows[$];

    int unsigned n_errors = 0;
    int unsigned n_words = 0;
    int unsigned n_results = 0;
    int unsigned n_mod_writes = 0;
    int unsigned n_drains = 0;
    int unsigned idle_cycles = 0;

    modular_exponentiation_core #(
        .OPERAND_WIDTH(W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_value     (i_base_value),
        .i_exponent_value (i_exponent_value),
        .o_result_strobe  (o_result_strobe),
        .o_power_residue  (o_power_residue),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // right-to-left square-and-multiply with double-width products, so the
    // squares never overflow; modulus 0 or 1 gives 0
    function automatic logic [W-1:0] power_mod(input logic [W-1:0] base_in,
                                               input logic [W-1:0] expo_in,
                                               input logic [W-1:0] m);
        logic [2*W-1:0] acc;
        logic [2*W-1:0] sq;
        logic [W-1:0]   expo;
        if (m <= 1) begin
            return '0;
        end
        acc  = (2*W)'(1);
        sq   = (2*W)'(base_in % m);
        expo = expo_in;
        while (expo != 0) begin
            if (expo[0]) begin
                acc = (acc * sq) % m;
            end
            sq   = (sq * sq) % m;
            expo = expo >> 1;
        end
        return acc[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_operand();
        logic [31:0] r;
        r = $urandom();
        return r[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_between(input int unsigned lo, input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[W-1:0];
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(4, 1);
        end
        return $urandom_range(150, 20);
    endfunction

    function automatic t_row row(input t_row_kind kind, input logic [W-1:0] a,
                                 input logic [W-1:0] b, input logic typed,
                                 input logic [W-1:0] want);
        t_row r;
        r.kind  = kind;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // present one command word; start stays high across back-to-back words
    // and is dropped only for a gap, a drain or a modulus write
    task automatic send_word(input logic [W-1:0] base_v, input logic [W-1:0] expo_v,
                             input int unsigned gap, input logic typed,
                             input logic [W-1:0] want);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_base_value     <= base_v;
        i_exponent_value <= expo_v;
        do @(posedge i_clk); while (busy !== 1'b0);
        residue_q.push_back(typed ? want : power_mod(base_v, expo_v, modulus_shadow));
        n_words++;
    endtask

    // hold off until every residue is back
    task automatic drain();
        while (residue_q.size() != 0) @(posedge i_clk);
    endtask

    // modulus writes only go in with the core idle and nothing pending
    task automatic write_modulus(input logic [W-1:0] value);
        start <= 1'b0;
        drain();
        repeat (pick_gap()) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid    <= 1'b0;
        modulus_shadow  = value;
        n_mod_writes++;
    endtask

    // result checker: every strobe pops the oldest expected residue
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe === 1'b1) begin
            n_results++;
            if (residue_q.size() == 0) begin
                report_mismatch("residue with nothing pending", o_power_residue, '0);
            end else begin
                residue_want = residue_q.pop_front();
                if (o_power_residue !== residue_want) begin
                    report_mismatch("power_residue", o_power_residue, residue_want);
                end
            end
        end
    end

    // watchdog: counts cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || (i_cfg_valid && o_cfg_ready === 1'b1)
                || o_result_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d residues pending",
                     idle_cycles, residue_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] base_v;
        logic [W-1:0] expo_v;
        logic [W-1:0] mask;
        logic [W-1:0] mod_v;
        logic         burst;

        // directed table: typed results only where they are plain to see
        // modulus at reset, small power, exponent zero, zero base, base above modulus
        directed_rows.push_back(row(ROW_ITEM, 2, 10, 1'b1, 1024));
        directed_rows.push_back(row(ROW_ITEM, 0, 0, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX, 0, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, 0, 5, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX, 1, 1'b1,
                                    OPERAND_MAX - 2 * MODULUS_AT_RESET));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX, OPERAND_MAX, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, 1, OPERAND_MAX, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, 3, OPERAND_MAX, 1'b0, 0));
        // modulus one: always zero, even for exponent zero
        directed_rows.push_back(row(ROW_CFG, 1, 0, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, 5, 3, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX, OPERAND_MAX, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, 0, 0, 1'b1, 0));
        // modulus zero behaves like one
        directed_rows.push_back(row(ROW_CFG, 0, 0, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, 7, 9, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, 0, 0, 1'b1, 0));
        // largest modulus: base equal to it, base of minus one
        directed_rows.push_back(row(ROW_CFG, OPERAND_MAX, 0, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX, 5, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX - 1, 2, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX - 1, 3, 1'b1, OPERAND_MAX - 1));
        directed_rows.push_back(row(ROW_ITEM, 12345, OPERAND_MAX, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, OPERAND_MAX - 1, OPERAND_MAX, 1'b0, 0));
        // smallest real modulus
        directed_rows.push_back(row(ROW_CFG, 2, 0, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, 3, OPERAND_MAX, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, 4, 1, 1'b1, 0));
        directed_rows.push_back(row(ROW_ITEM, 0, 0, 1'b1, 1));
        // small prime, 2^12 mod 13 is 1
        directed_rows.push_back(row(ROW_CFG, 13, 0, 1'b0, 0));
        directed_rows.push_back(row(ROW_ITEM, 2, 12, 1'b1, 1));
        directed_rows.push_back(row(ROW_ITEM, 100, 0, 1'b1, 1));

        // single reset pulse
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_modulus(directed_rows[i].a);
            end else begin
                send_word(directed_rows[i].a, directed_rows[i].b, pick_gap(),
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // random phases, each under its own modulus
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       mod_v = rand_between(2, 255);
                1:       mod_v = OPERAND_MAX;
                2:       mod_v = 1;
                3:       mod_v = rand_between(32'h4000_0000, 32'h7fff_ffff);
                4:       mod_v = rand_between(2, 65535);
                5:       mod_v = MODULUS_AT_RESET;
                default: mod_v = rand_operand();
            endcase
            write_modulus(mod_v);
            // about one phase in four runs without sender gaps
            burst = ($urandom_range(3, 0) == 0);
            for (int unsigned k = 0; k < WORDS_PER_PHASE; k++) begin
                case ($urandom_range(7, 0))
                    0:       base_v = 0;
                    1:       base_v = 1;
                    2:       base_v = modulus_shadow - 1;
                    3:       base_v = rand_between(0, 255);
                    default: base_v = rand_operand();
                endcase
                // exponent bit length sets the latency, so most are shorter
                case ($urandom_range(7, 0))
                    0:       expo_v = 0;
                    1:       expo_v = OPERAND_MAX;
                    2, 3:    expo_v = rand_operand();
                    default: begin
                        mask   = OPERAND_MAX >> $urandom_range(W - 1, 0);
                        expo_v = rand_operand() & mask;
                    end
                endcase
                // sometimes hold off until the core has caught up
                if ($urandom_range(29, 0) == 0) begin
                    start <= 1'b0;
                    drain();
                    n_drains++;
                end
                send_word(base_v, expo_v, burst ? 0 : pick_gap(), 1'b0, '0);
            end
        end

        // wrap up: everything back, then a quiet window for stray strobes
        start <= 1'b0;
        drain();
        n_drains++;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words (%0d directed rows) under %0d modulus writes",
                 n_words, directed_rows.size(), n_mod_writes);
        $display("checked %0d residues, %0d full drains, %0d mismatches",
                 n_results, n_drains, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation_core.sv
test/modular_exponentiation_core_tb.sv
